>>> hw/rtl/iir_filter_direct_form_two_top_macros.svh
// Assertion macros shared by the IIR filter RTL.
`ifndef IIR_FILTER_DIRECT_FORM_TWO_TOP_MACROS_SVH
`define IIR_FILTER_DIRECT_FORM_TWO_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define IIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/iirdf2_pkg.sv
// Package: widths, control word types and microprogram of the IIR filter.
package iirdf2_pkg;

    localparam int MAX_NUMER   = 3;
    localparam int MAX_DENOM   = 2;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;
    localparam int HIST_BITS   = SAMPLE_BITS + 8;
    localparam int HIST_DEPTH  = 3;
    localparam int COEF_FRAC   = COEF_BITS - 4;
    localparam int PROD_BITS   = COEF_BITS + HIST_BITS;
    localparam int ACC_BITS    = PROD_BITS + 2;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [1:0] NUM_LIMIT = 2'((MAX_NUMER < 3) ? MAX_NUMER : 3);
    localparam logic [1:0] DEN_LIMIT = 2'((MAX_DENOM < 2) ? MAX_DENOM : 2);

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        ACC_BITS'(64'sd1 <<< (COEF_FRAC - 1));
    localparam logic signed [ACC_BITS-1:0] HIST_MAX =
        ACC_BITS'((64'sd1 <<< (HIST_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_BITS-1:0] HIST_MIN = ~HIST_MAX;
    localparam logic signed [ACC_BITS-1:0] SAMP_MAX =
        ACC_BITS'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_BITS-1:0] SAMP_MIN = ~SAMP_MAX;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_NUMER_TAPS = 3'd0,
        CFG_DENOM_TAPS = 3'd1,
        CFG_COEF_B0    = 3'd2,
        CFG_COEF_B1    = 3'd3,
        CFG_COEF_B2    = 3'd4,
        CFG_COEF_A1    = 3'd5,
        CFG_COEF_A2    = 3'd6
    } t_cfg_idx;

    typedef logic [3:0] t_pc;

    localparam t_pc PC_IDLE = 4'd0;
    localparam t_pc PC_FB0  = 4'd1;
    localparam t_pc PC_FB1  = 4'd2;
    localparam t_pc PC_FB2  = 4'd3;
    localparam t_pc PC_W    = 4'd4;
    localparam t_pc PC_NB0  = 4'd5;
    localparam t_pc PC_NB1  = 4'd6;
    localparam t_pc PC_NB2  = 4'd7;
    localparam t_pc PC_NB3  = 4'd8;
    localparam t_pc PC_OUT  = 4'd9;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_X,
        ACC_LOAD_RND,
        ACC_ADD,
        ACC_SUB
    } t_acc_op;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_A1_H0,
        MUL_A2_H1,
        MUL_B0_H0,
        MUL_B1_H1,
        MUL_B2_H2
    } t_mul_sel;

    typedef enum logic [2:0] {
        JMP_NEXT,
        JMP_IN_WAIT,
        JMP_ND_LE,
        JMP_NN_LE,
        JMP_OUT_WAIT
    } t_jmp;

    typedef struct packed {
        t_acc_op    acc_op;
        t_mul_sel   mul_sel;
        logic       shift_hist;
        t_jmp       jmp;
        logic [1:0] cmp;
        t_pc        target;
    } t_uword;

    // Microprogram: feedback taps, history update, numerator taps, output.
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        w = '{ACC_HOLD, MUL_NONE, 1'b0, JMP_IN_WAIT, 2'd0, PC_FB0};
        unique case (pc)
            PC_IDLE: w = '{ACC_LOAD_X,   MUL_NONE,  1'b0, JMP_IN_WAIT,  2'd0, PC_FB0};
            PC_FB0:  w = '{ACC_HOLD,     MUL_A1_H0, 1'b0, JMP_ND_LE,    2'd0, PC_W};
            PC_FB1:  w = '{ACC_SUB,      MUL_A2_H1, 1'b0, JMP_ND_LE,    2'd1, PC_W};
            PC_FB2:  w = '{ACC_SUB,      MUL_NONE,  1'b0, JMP_NEXT,     2'd0, PC_W};
            PC_W:    w = '{ACC_LOAD_RND, MUL_NONE,  1'b1, JMP_NEXT,     2'd0, PC_NB0};
            PC_NB0:  w = '{ACC_HOLD,     MUL_B0_H0, 1'b0, JMP_NN_LE,    2'd0, PC_OUT};
            PC_NB1:  w = '{ACC_ADD,      MUL_B1_H1, 1'b0, JMP_NN_LE,    2'd1, PC_OUT};
            PC_NB2:  w = '{ACC_ADD,      MUL_B2_H2, 1'b0, JMP_NN_LE,    2'd2, PC_OUT};
            PC_NB3:  w = '{ACC_ADD,      MUL_NONE,  1'b0, JMP_NEXT,     2'd0, PC_OUT};
            PC_OUT:  w = '{ACC_HOLD,     MUL_NONE,  1'b0, JMP_OUT_WAIT, 2'd0, PC_IDLE};
            default: w = '{ACC_HOLD,     MUL_NONE,  1'b0, JMP_OUT_WAIT, 2'd0, PC_IDLE};
        endcase
        return w;
    endfunction

    // Drop the fraction bits and clamp to the history range.
    function automatic logic signed [HIST_BITS-1:0] sat_hist(
        input logic signed [ACC_BITS-1:0] acc
    );
        logic signed [ACC_BITS-1:0] s;
        s = acc >>> COEF_FRAC;
        if (s > HIST_MAX) begin
            return HIST_MAX[HIST_BITS-1:0];
        end else if (s < HIST_MIN) begin
            return HIST_MIN[HIST_BITS-1:0];
        end
        return s[HIST_BITS-1:0];
    endfunction

    // Clamp a sample-scale value to the output range.
    function automatic logic signed [SAMPLE_BITS-1:0] sat_samp(
        input logic signed [ACC_BITS-1:0] v
    );
        if (v > SAMP_MAX) begin
            return SAMP_MAX[SAMPLE_BITS-1:0];
        end else if (v < SAMP_MIN) begin
            return SAMP_MIN[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

>>> hw/rtl/iir_filter_direct_form_two_top.sv
// Input beats are taken only while the sequencer is idle. One shared 18x24 multiplier and
// accumulator walk the feedback taps, the history update, the numerator taps and the output
// step in turn, skipping unused taps. A full output register holds the sequencer in the final
// step, and no new beat is taken until the result has been loaded into that register.
// Reset (synchronous, active low) restores the register defaults, zeroes the history
// and leaves the sequencer idle with no output beat pending.
`include "iir_filter_direct_form_two_top_macros.svh"

module iir_filter_direct_form_two_top (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    // sample input channel
    input  logic                                         i_in_valid,
    output logic                                         o_in_stall,
    input  logic signed [iirdf2_pkg::SAMPLE_BITS-1:0]    i_sample_in,
    input  logic                                         i_restart,
    // sample output channel
    output logic                                         o_out_valid,
    input  logic                                         i_out_stall,
    output logic signed [iirdf2_pkg::SAMPLE_BITS-1:0]    o_sample_out,
    // configuration write channel
    input  logic                                         i_cfg_valid,
    output logic                                         o_cfg_ready,
    input  logic [iirdf2_pkg::CFG_IDX_BITS-1:0]          i_cfg_index,
    input  logic [iirdf2_pkg::COEF_BITS-1:0]             i_cfg_data
);

    localparam int SB = iirdf2_pkg::SAMPLE_BITS;
    localparam int CB = iirdf2_pkg::COEF_BITS;
    localparam int HB = iirdf2_pkg::HIST_BITS;
    localparam int PB = iirdf2_pkg::PROD_BITS;
    localparam int AB = iirdf2_pkg::ACC_BITS;

    // configuration registers
    logic [1:0]           r_numer_taps;
    logic [1:0]           r_denom_taps;
    logic signed [CB-1:0] r_coef_b0;
    logic signed [CB-1:0] r_coef_b1;
    logic signed [CB-1:0] r_coef_b2;
    logic signed [CB-1:0] r_coef_a1;
    logic signed [CB-1:0] r_coef_a2;

    // sequencer and datapath
    iirdf2_pkg::t_pc      r_pc;
    iirdf2_pkg::t_pc      n_pc;
    iirdf2_pkg::t_uword   uw;
    logic signed [HB-1:0] r_hist [iirdf2_pkg::HIST_DEPTH];
    logic signed [PB-1:0] r_prod;
    logic signed [PB-1:0] n_prod;
    logic signed [AB-1:0] r_acc;
    logic signed [AB-1:0] n_acc;
    logic signed [CB-1:0] mul_coef;
    logic signed [HB-1:0] mul_hist;
    logic signed [HB-1:0] w_val;
    logic signed [SB-1:0] y_val;
    logic signed [SB-1:0] r_out_data;
    logic                 r_out_valid;
    logic [1:0]           nd;
    logic [1:0]           nn;
    logic                 in_accept;
    logic                 out_free;

    assign uw          = iirdf2_pkg::ucode(r_pc);
    assign o_in_stall  = (r_pc != iirdf2_pkg::PC_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_sample_out = r_out_data;
    assign o_cfg_ready = 1'b1;

    // clamp tap counts to what the coefficient set holds
    assign nd = (r_denom_taps > iirdf2_pkg::DEN_LIMIT) ? iirdf2_pkg::DEN_LIMIT : r_denom_taps;
    assign nn = (r_numer_taps > iirdf2_pkg::NUM_LIMIT) ? iirdf2_pkg::NUM_LIMIT : r_numer_taps;

    // next step: advance, branch on tap count, or hold for a handshake
    always_comb begin
        n_pc = 4'(r_pc + 4'd1);
        unique case (uw.jmp)
            iirdf2_pkg::JMP_NEXT:     n_pc = 4'(r_pc + 4'd1);
            iirdf2_pkg::JMP_IN_WAIT:  n_pc = in_accept ? uw.target : r_pc;
            iirdf2_pkg::JMP_ND_LE:    n_pc = (nd <= uw.cmp) ? uw.target : 4'(r_pc + 4'd1);
            iirdf2_pkg::JMP_NN_LE:    n_pc = (nn <= uw.cmp) ? uw.target : 4'(r_pc + 4'd1);
            iirdf2_pkg::JMP_OUT_WAIT: n_pc = out_free ? uw.target : r_pc;
            default: ;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_coef = r_coef_a1;
        mul_hist = r_hist[0];
        unique case (uw.mul_sel)
            iirdf2_pkg::MUL_NONE:  begin mul_coef = r_coef_a1; mul_hist = r_hist[0]; end
            iirdf2_pkg::MUL_A1_H0: begin mul_coef = r_coef_a1; mul_hist = r_hist[0]; end
            iirdf2_pkg::MUL_A2_H1: begin mul_coef = r_coef_a2; mul_hist = r_hist[1]; end
            iirdf2_pkg::MUL_B0_H0: begin mul_coef = r_coef_b0; mul_hist = r_hist[0]; end
            iirdf2_pkg::MUL_B1_H1: begin mul_coef = r_coef_b1; mul_hist = r_hist[1]; end
            iirdf2_pkg::MUL_B2_H2: begin mul_coef = r_coef_b2; mul_hist = r_hist[2]; end
            default: ;
        endcase
        n_prod = (uw.mul_sel == iirdf2_pkg::MUL_NONE) ? r_prod : PB'(mul_coef * mul_hist);
    end

    // accumulator; the rounding offset is preloaded so a plain shift rounds half up
    always_comb begin
        n_acc = r_acc;
        unique case (uw.acc_op)
            iirdf2_pkg::ACC_HOLD:     n_acc = r_acc;
            iirdf2_pkg::ACC_LOAD_X:   n_acc = (AB'(i_sample_in) <<< iirdf2_pkg::COEF_FRAC)
                                              + iirdf2_pkg::ROUND_HALF;
            iirdf2_pkg::ACC_LOAD_RND: n_acc = iirdf2_pkg::ROUND_HALF;
            iirdf2_pkg::ACC_ADD:      n_acc = r_acc + AB'(r_prod);
            iirdf2_pkg::ACC_SUB:      n_acc = r_acc - AB'(r_prod);
            default: ;
        endcase
    end

    assign w_val = iirdf2_pkg::sat_hist(r_acc);
    // with no numerator taps, pass the feedback value straight out
    assign y_val = (nn == 2'd0) ? iirdf2_pkg::sat_samp(AB'(r_hist[0]))
                                : iirdf2_pkg::sat_samp(r_acc >>> iirdf2_pkg::COEF_FRAC);

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_acc  <= n_acc;
        if (r_pc == iirdf2_pkg::PC_OUT && out_free) begin
            r_out_data <= y_val;
        end
        if (!i_rst_n) begin
            r_pc         <= iirdf2_pkg::PC_IDLE;
            r_out_valid  <= 1'b0;
            r_numer_taps <= 2'd3;
            r_denom_taps <= 2'd2;
            r_coef_b0    <= CB'(16384);
            r_coef_b1    <= '0;
            r_coef_b2    <= '0;
            r_coef_a1    <= '0;
            r_coef_a2    <= '0;
            for (int i = 0; i < iirdf2_pkg::HIST_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_pc <= n_pc;
            // output register: load on the final step, drop once taken
            if (r_pc == iirdf2_pkg::PC_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            // history: clear on restart, shift in w on the update step
            if (in_accept && i_restart) begin
                for (int i = 0; i < iirdf2_pkg::HIST_DEPTH; i++) begin
                    r_hist[i] <= '0;
                end
            end else if (uw.shift_hist) begin
                for (int i = iirdf2_pkg::HIST_DEPTH - 1; i > 0; i--) begin
                    r_hist[i] <= r_hist[i-1];
                end
                r_hist[0] <= w_val;
            end
            // configuration writes; unknown indexes are ignored
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    iirdf2_pkg::CFG_NUMER_TAPS: r_numer_taps <= i_cfg_data[1:0];
                    iirdf2_pkg::CFG_DENOM_TAPS: r_denom_taps <= i_cfg_data[1:0];
                    iirdf2_pkg::CFG_COEF_B0:    r_coef_b0    <= i_cfg_data;
                    iirdf2_pkg::CFG_COEF_B1:    r_coef_b1    <= i_cfg_data;
                    iirdf2_pkg::CFG_COEF_B2:    r_coef_b2    <= i_cfg_data;
                    iirdf2_pkg::CFG_COEF_A1:    r_coef_a1    <= i_cfg_data;
                    iirdf2_pkg::CFG_COEF_A2:    r_coef_a2    <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    `IIR_ASSERT_NEXT(a_accept_starts, in_accept, r_pc == iirdf2_pkg::PC_FB0, "accept did not start program")
    `IIR_ASSERT_NOW(a_out_from_final, $rose(r_out_valid), $past(r_pc) == iirdf2_pkg::PC_OUT, "output loaded outside final step")
    `IIR_ASSERT_NEXT(a_hist_shift, r_pc == iirdf2_pkg::PC_W, r_hist[1] == $past(r_hist[0]), "history did not shift on update")

endmodule
